[hdl/dsu_pkg.sv]
// ----------------------------------------------------------------------------
// dsu_pkg
// Shared constants, types and register codes of the union-find block.
// ----------------------------------------------------------------------------
package dsu_pkg;

    localparam int MAX_NODES = 1024;
    localparam int NW        = $clog2(MAX_NODES);
    localparam int CW        = NW + 1;
    localparam int SW        = 11;
    localparam int RW        = 4;

    localparam logic [SW-1:0] SIZE_MAX  = '1;
    localparam logic [RW-1:0] RANK_MAX  = '1;
    localparam logic [CW-1:0] COUNT_MAX = '1;
    localparam logic [CW-1:0] NODES_C   = CW'(MAX_NODES);

    typedef enum logic {
        REG_UNION_MODE = 1'b0,
        REG_NODE_COUNT = 1'b1
    } dsu_reg_t;

    typedef enum logic {
        CMD_FIND  = 1'b0,
        CMD_UNION = 1'b1
    } dsu_command_t;

    typedef enum logic {
        MODE_SIZE = 1'b0,
        MODE_RANK = 1'b1
    } dsu_mode_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_F_RD,
        S_F_CMP,
        S_C_RD,
        S_C_WR,
        S_M_RD2,
        S_M_CALC,
        S_OUT
    } dsu_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_FAIL,
        OP_F_RD,
        OP_F_CMP,
        OP_C_RD,
        OP_C_WR,
        OP_SWAP_B,
        OP_FINISH,
        OP_M_RD1,
        OP_M_RD2,
        OP_M_CALC
    } dsu_op_t;

    typedef struct packed {
        dsu_op_t op;
    } dsu_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic bad_range;
        logic is_union;
        logic is_root;
        logic at_root;
        logic roots_equal;
    } dsu_stat_t;

endpackage

[hdl/dsu_ram.sv]
// ----------------------------------------------------------------------------
// dsu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/dsu_ctrl.sv]
// ----------------------------------------------------------------------------
// dsu_ctrl
// Sequencer of the union-find block: clearing pass, root walks, path
// compression, linking and result handshake.
// ----------------------------------------------------------------------------
module dsu_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  dsu_pkg::dsu_stat_t stat,
    output dsu_pkg::dsu_cmd_t  cmd
);
    import dsu_pkg::*;

    dsu_state_t state_reg, state_next;
    logic       second_reg, second_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            second_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            second_reg <= second_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        second_next = second_reg;
        case (state_reg)
            S_CLEAR: begin
                if (stat.clear_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                second_next = 1'b0;
                state_next  = stat.bad_range ? S_OUT : S_F_RD;
            end
            S_F_RD:  state_next = S_F_CMP;
            S_F_CMP: state_next = stat.is_root ? S_C_RD : S_F_RD;
            S_C_RD: begin
                if (!stat.at_root) begin
                    state_next = S_C_WR;
                end else if (stat.is_union && !second_reg) begin
                    second_next = 1'b1;
                    state_next  = S_F_RD;
                end else if (stat.is_union && !stat.roots_equal) begin
                    state_next = S_M_RD2;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_C_WR:   state_next = S_C_RD;
            S_M_RD2:  state_next = S_M_CALC;
            S_M_CALC: state_next = S_OUT;
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb begin
        cmd.op  = OP_NONE;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            S_CLEAR: cmd.op = OP_CLEAR;
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = OP_LOAD;
                end
            end
            S_CHECK: begin
                if (stat.bad_range) begin
                    cmd.op = OP_FAIL;
                end
            end
            S_F_RD:  cmd.op = OP_F_RD;
            S_F_CMP: cmd.op = OP_F_CMP;
            S_C_RD: begin
                if (!stat.at_root) begin
                    cmd.op = OP_C_RD;
                end else if (stat.is_union && !second_reg) begin
                    cmd.op = OP_SWAP_B;
                end else if (stat.is_union && !stat.roots_equal) begin
                    cmd.op = OP_M_RD1;
                end else begin
                    cmd.op = OP_FINISH;
                end
            end
            S_C_WR:   cmd.op = OP_C_WR;
            S_M_RD2:  cmd.op = OP_M_RD2;
            S_M_CALC: cmd.op = OP_M_CALC;
            S_OUT:    m_valid = 1'b1;
            default:  cmd.op = OP_NONE;
        endcase
    end

endmodule

[hdl/dsu_datapath.sv]
// ----------------------------------------------------------------------------
// dsu_datapath
// Node stores, walk registers, link arithmetic, configuration registers and
// result registers of the union-find block.
// ----------------------------------------------------------------------------
module dsu_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dsu_pkg::dsu_cmd_t      cmd,
    output dsu_pkg::dsu_stat_t     stat,
    input  logic                   cfg_valid,
    input  logic                   cfg_index,
    input  logic [dsu_pkg::CW-1:0] cfg_data,
    input  logic                   s_command,
    input  logic [dsu_pkg::NW-1:0] s_node_a,
    input  logic [dsu_pkg::NW-1:0] s_node_b,
    output logic [dsu_pkg::NW-1:0] m_root,
    output logic                   m_merged,
    output logic [dsu_pkg::CW-1:0] m_component_count,
    output logic                   m_status
);
    import dsu_pkg::*;

    logic            mode_reg;
    logic [CW-1:0]   ncount_reg;
    logic [CW-1:0]   clr_reg;
    logic [CW-1:0]   merge_reg;
    logic            cmd_reg;
    logic [NW-1:0]   a_reg, b_reg, cur_reg, start_reg, root_reg, ra_reg;
    logic [SW-1:0]   size_a_reg;
    logic [RW-1:0]   rank_a_reg;
    logic [NW-1:0]   out_root_reg;
    logic            out_merged_reg, out_status_reg;

    logic [CW-1:0]   n_use;
    logic [NW-1:0]   parent_q, size_raddr, p_waddr, p_wdata, sr_waddr;
    logic [SW-1:0]   size_q, size_wdata, size_new;
    logic [RW-1:0]   rank_q, rank_wdata, rank_new;
    logic            p_we, size_we, rank_we;
    logic            a_on_top;
    logic [NW-1:0]   top, low;
    logic [SW:0]     size_sum;

    assign n_use = (ncount_reg > NODES_C) ? NODES_C : ncount_reg;

    always_comb begin
        if (mode_reg == MODE_SIZE) begin
            a_on_top = !(size_a_reg < size_q);
        end else begin
            a_on_top = !(rank_a_reg < rank_q);
        end
        top      = a_on_top ? ra_reg : root_reg;
        low      = a_on_top ? root_reg : ra_reg;
        size_sum = {1'b0, size_a_reg} + {1'b0, size_q};
        size_new = (size_sum > {1'b0, SIZE_MAX}) ? SIZE_MAX : size_sum[SW-1:0];
        rank_new = a_on_top ? rank_a_reg : rank_q;
        if (rank_a_reg == rank_q && rank_new < RANK_MAX) begin
            rank_new = rank_new + RW'(1);
        end
    end

    always_comb begin
        p_we       = 1'b0;
        p_waddr    = cur_reg;
        p_wdata    = root_reg;
        size_we    = 1'b0;
        rank_we    = 1'b0;
        sr_waddr   = top;
        size_wdata = size_new;
        rank_wdata = rank_new;
        size_raddr = (cmd.op == OP_M_RD1) ? ra_reg : root_reg;
        case (cmd.op)
            OP_CLEAR: begin
                p_we       = 1'b1;
                p_waddr    = clr_reg[NW-1:0];
                p_wdata    = clr_reg[NW-1:0];
                size_we    = 1'b1;
                rank_we    = 1'b1;
                sr_waddr   = clr_reg[NW-1:0];
                size_wdata = SW'(1);
                rank_wdata = '0;
            end
            OP_C_WR: p_we = 1'b1;
            OP_M_CALC: begin
                p_we    = 1'b1;
                p_waddr = low;
                p_wdata = top;
                size_we = (mode_reg == MODE_SIZE);
                rank_we = (mode_reg == MODE_RANK);
            end
            default: p_we = 1'b0;
        endcase
    end

    dsu_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_parent (
        .aclk(aclk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(cur_reg), .rdata(parent_q)
    );

    dsu_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_size (
        .aclk(aclk), .we(size_we), .waddr(sr_waddr), .wdata(size_wdata),
        .raddr(size_raddr), .rdata(size_q)
    );

    dsu_ram #(.WIDTH(RW), .DEPTH(MAX_NODES)) u_rank (
        .aclk(aclk), .we(rank_we), .waddr(sr_waddr), .wdata(rank_wdata),
        .raddr(size_raddr), .rdata(rank_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_SIZE;
            ncount_reg <= NODES_C;
            clr_reg    <= '0;
            merge_reg  <= '0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == REG_UNION_MODE) begin
                    mode_reg <= cfg_data[0];
                end else begin
                    ncount_reg <= cfg_data;
                end
            end
            if (cmd.op == OP_CLEAR) begin
                clr_reg <= clr_reg + CW'(1);
            end
            if (cmd.op == OP_M_CALC && merge_reg < COUNT_MAX) begin
                merge_reg <= merge_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                cmd_reg   <= s_command;
                a_reg     <= s_node_a;
                b_reg     <= s_node_b;
                cur_reg   <= s_node_a;
                start_reg <= s_node_a;
            end
            OP_F_CMP: begin
                if (parent_q == cur_reg) begin
                    root_reg <= cur_reg;
                    cur_reg  <= start_reg;
                end else begin
                    cur_reg <= parent_q;
                end
            end
            OP_C_WR: cur_reg <= parent_q;
            OP_SWAP_B: begin
                ra_reg    <= root_reg;
                cur_reg   <= b_reg;
                start_reg <= b_reg;
            end
            OP_M_RD2: begin
                size_a_reg <= size_q;
                rank_a_reg <= rank_q;
            end
            OP_FAIL: begin
                out_root_reg   <= '0;
                out_merged_reg <= 1'b0;
                out_status_reg <= 1'b1;
            end
            OP_FINISH: begin
                out_root_reg   <= root_reg;
                out_merged_reg <= 1'b0;
                out_status_reg <= 1'b0;
            end
            OP_M_CALC: begin
                out_root_reg   <= top;
                out_merged_reg <= 1'b1;
                out_status_reg <= 1'b0;
            end
            default: cur_reg <= cur_reg;
        endcase
    end

    assign stat.clear_done  = (clr_reg[NW-1:0] == {NW{1'b1}});
    assign stat.bad_range   = ({1'b0, a_reg} >= n_use)
                            || (cmd_reg == CMD_UNION && {1'b0, b_reg} >= n_use);
    assign stat.is_union    = (cmd_reg == CMD_UNION);
    assign stat.is_root     = (parent_q == cur_reg);
    assign stat.at_root     = (cur_reg == root_reg);
    assign stat.roots_equal = (ra_reg == root_reg);

    assign m_root            = out_root_reg;
    assign m_merged          = out_merged_reg;
    assign m_status          = out_status_reg;
    assign m_component_count = (n_use > merge_reg) ? (n_use - merge_reg) : '0;

endmodule

[hdl/disjoint_set_union_find.sv]
// ----------------------------------------------------------------------------
// disjoint_set_union_find
// Union-find over a 1024-node store with path compression and union by
// size or rank.
// ----------------------------------------------------------------------------
// A command enters on the s_ channel: a find of s_node_a or a union of
// s_node_a and s_node_b. One result leaves on the m_ channel for each
// command, giving the root, the merge flag, the component count and status.
// Registers are written on the cfg_ channel, which is always ready.
// After reset a clearing pass initializes the parent, size and rank stores;
// no command is taken during it.
// One command is processed at a time. After the input transfer, the block
// walks from s_node_a to its root and then relinks each node on that path
// to the root by compression; a union repeats this for s_node_b and links
// the two roots when they differ. Each node store has one read port. A
// rejected command skips the walks and goes straight to its result.
// s_ready returns the cycle after the result transfer.
// The result is held in the output register until its transfer completes;
// s_ready stays low while the receiver stalls.
// ----------------------------------------------------------------------------
module disjoint_set_union_find (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [dsu_pkg::CW-1:0] cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_command,
    input  logic [dsu_pkg::NW-1:0] s_node_a,
    input  logic [dsu_pkg::NW-1:0] s_node_b,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [dsu_pkg::NW-1:0] m_root,
    output logic                   m_merged,
    output logic [dsu_pkg::CW-1:0] m_component_count,
    output logic                   m_status
);
    import dsu_pkg::*;

    dsu_cmd_t  cmd;
    dsu_stat_t stat;

    assign cfg_ready = 1'b1;

    dsu_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready),
        .stat(stat), .cmd(cmd)
    );

    dsu_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .stat(stat),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_command(s_command), .s_node_a(s_node_a), .s_node_b(s_node_b),
        .m_root(m_root), .m_merged(m_merged),
        .m_component_count(m_component_count), .m_status(m_status)
    );

endmodule

[hdl/dsu_checker.sv]
// ----------------------------------------------------------------------------
// dsu_checker
// Port-level checks of the union-find block, bound to the top level.
// ----------------------------------------------------------------------------
module dsu_checker (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [dsu_pkg::NW-1:0] m_root,
    input logic                   m_merged,
    input logic                   m_status
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_root) && $stable(m_merged))
        else $error("Result changed while stalled.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("Command taken while a result waits.");

    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Second command taken before a result.");

    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> !m_merged && m_root == '0)
        else $error("Rejected command reports a merge or root.");

endmodule

bind disjoint_set_union_find dsu_checker u_dsu_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready),
    .m_root(m_root), .m_merged(m_merged), .m_status(m_status)
);

[tb/disjoint_set_union_find_tb.sv]
// ----------------------------------------------------------------------------
// disjoint_set_union_find_tb
// Self-checking testbench for the union-find block. A behavioral forest
// predicts root, merge flag, component count and status for each command,
// and every result transfer is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module disjoint_set_union_find_tb;
    import dsu_pkg::*;

    typedef struct packed {
        logic [NW-1:0] root;
        logic          merged;
        logic [CW-1:0] count;
        logic          status;
    } dsu_result_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic          cfg_index = 1'b0;
    logic [CW-1:0] cfg_data = '0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic          s_command = 1'b0;
    logic [NW-1:0] s_node_a = '0;
    logic [NW-1:0] s_node_b = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [NW-1:0] m_root;
    logic          m_merged;
    logic [CW-1:0] m_component_count;
    logic          m_status;

    dsu_mode_t     mode_q;
    logic [CW-1:0] nodes_q;
    logic [NW-1:0] link_q  [MAX_NODES];
    logic [SW-1:0] size_q  [MAX_NODES];
    logic [RW-1:0] rank_q  [MAX_NODES];
    logic [CW-1:0] merges_q;

    dsu_result_t   pending_results[$];
    int            error_count = 0;
    int            cycle_count = 0;
    bit            no_idle = 1'b0;
    int            stall_left = 0;

    disjoint_set_union_find dut (.*);

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int active_nodes();
        return (nodes_q > MAX_NODES) ? MAX_NODES : int'(nodes_q);
    endfunction

    function automatic logic [CW-1:0] components();
        int c;
        c = active_nodes() - int'(merges_q);
        if (c < 0) c = 0;
        return CW'(c);
    endfunction

    function automatic logic [NW-1:0] find_root(logic [NW-1:0] start);
        logic [NW-1:0] r, cur, nxt;
        r = start;
        while (link_q[r] != r) r = link_q[r];
        cur = start;
        while (cur != r) begin
            nxt = link_q[cur];
            link_q[cur] = r;
            cur = nxt;
        end
        return r;
    endfunction

    function automatic dsu_result_t predict_command(dsu_command_t cmd,
                                                    logic [NW-1:0] a,
                                                    logic [NW-1:0] b);
        dsu_result_t   res;
        logic [NW-1:0] ra, rb, top, low;
        int            s;
        res = '0;
        if (a >= active_nodes() || (cmd == CMD_UNION && b >= active_nodes())) begin
            res.status = 1'b1;
        end else if (cmd == CMD_FIND) begin
            res.root = find_root(a);
        end else begin
            ra = find_root(a);
            rb = find_root(b);
            res.root = ra;
            if (ra != rb) begin
                if (mode_q == MODE_SIZE) begin
                    if (size_q[ra] < size_q[rb]) begin
                        top = rb; low = ra;
                    end else begin
                        top = ra; low = rb;
                    end
                    s = size_q[top] + size_q[low];
                    size_q[top] = (s > SIZE_MAX) ? SIZE_MAX : SW'(s);
                end else begin
                    if (rank_q[ra] < rank_q[rb]) begin
                        top = rb; low = ra;
                    end else begin
                        top = ra; low = rb;
                    end
                    if (rank_q[ra] == rank_q[rb] && rank_q[top] < RANK_MAX)
                        rank_q[top] = rank_q[top] + RW'(1);
                end
                link_q[low] = top;
                res.root = top;
                res.merged = 1'b1;
                if (merges_q < COUNT_MAX) merges_q = merges_q + CW'(1);
            end
        end
        res.count = components();
        return res;
    endfunction

    task automatic idle_gap();
        if (!no_idle && $urandom_range(3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    task automatic send_command(dsu_command_t cmd, logic [NW-1:0] a, logic [NW-1:0] b);
        idle_gap();
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_node_a  <= a;
        s_node_b  <= b;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_command(cmd, a, b));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_register(dsu_reg_t idx, logic [CW-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_UNION_MODE) mode_q = dsu_mode_t'(value[0]);
        else nodes_q = value;
    endtask

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result root=%0d", m_root);
                error_count++;
            end else begin
                dsu_result_t e;
                e = pending_results.pop_front();
                if (m_root !== e.root) begin
                    $error("root: expected %0d, got %0d", e.root, m_root); error_count++;
                end
                if (m_merged !== e.merged) begin
                    $error("merged: expected %0d, got %0d", e.merged, m_merged); error_count++;
                end
                if (m_component_count !== e.count) begin
                    $error("component_count: expected %0d, got %0d", e.count,
                           m_component_count);
                    error_count++;
                end
                if (m_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_status); error_count++;
                end
            end
        end
        if (no_idle) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(4) == 0) begin
            stall_left <= $urandom_range(0, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic test_directed();
        send_command(CMD_FIND, 10'd0, 10'd0);
        send_command(CMD_FIND, 10'd1023, 10'd1023);
        send_command(CMD_UNION, 10'd0, 10'd1023);
        send_command(CMD_UNION, 10'd1023, 10'd0);
        send_command(CMD_UNION, 10'd1, 10'd2);
        send_command(CMD_UNION, 10'd3, 10'd1);
        send_command(CMD_UNION, 10'd0, 10'd2);
        send_command(CMD_FIND, 10'd3, 10'h2AA);
        send_command(CMD_UNION, 10'h155, 10'h2AA);
        write_register(REG_NODE_COUNT, 11'd16);
        send_command(CMD_FIND, 10'd16, 10'd0);
        send_command(CMD_UNION, 10'd2, 10'd16);
        send_command(CMD_UNION, 10'd15, 10'd14);
        write_register(REG_NODE_COUNT, 11'd0);
        send_command(CMD_FIND, 10'd0, 10'd0);
        write_register(REG_NODE_COUNT, 11'd2047);
        send_command(CMD_FIND, 10'd1023, 10'd0);
    endtask

    task automatic test_rank_mode();
        write_register(REG_UNION_MODE, CW'(MODE_RANK));
        write_register(REG_NODE_COUNT, 11'd1);
        send_command(CMD_UNION, 10'd0, 10'd0);
        send_command(CMD_UNION, 10'd0, 10'd1);
        write_register(REG_NODE_COUNT, 11'd1024);
        send_command(CMD_UNION, 10'd20, 10'd21);
        send_command(CMD_UNION, 10'd22, 10'd23);
        send_command(CMD_UNION, 10'd22, 10'd20);
        send_command(CMD_FIND, 10'd21, 10'd0);
    endtask

    task automatic random_phase(int items, int span);
        logic [NW-1:0] a, b;
        for (int i = 0; i < items; i++) begin
            if ($urandom_range(19) == 0) begin
                a = NW'($urandom); b = NW'($urandom);
            end else begin
                a = NW'($urandom_range(span - 1)); b = NW'($urandom_range(span - 1));
            end
            send_command(dsu_command_t'($urandom_range(1)), a, b);
        end
    endtask

    task automatic test_random();
        random_phase(300, 64);
        write_register(REG_UNION_MODE, CW'(MODE_SIZE));
        random_phase(400, 1024);
        drain();
        write_register(REG_NODE_COUNT, 11'd40);
        random_phase(300, 48);
        write_register(REG_UNION_MODE, CW'(MODE_RANK));
        write_register(REG_NODE_COUNT, 11'd1024);
        random_phase(400, 1024);
        write_register(REG_NODE_COUNT, 11'd700);
        no_idle = 1'b1;
        random_phase(330, 720);
    endtask

    initial begin
        mode_q   = MODE_SIZE;
        nodes_q  = 11'd1024;
        merges_q = '0;
        for (int i = 0; i < MAX_NODES; i++) begin
            link_q[i] = NW'(i);
            size_q[i] = SW'(1);
            rank_q[i] = '0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_rank_mode();
        test_random();
        drain();
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
